@@ sv/xtea_pkg.sv @@
// Shared types, constants and helper functions for the XTEA CBC block cipher.
`timescale 1ns / 1ps

package xtea_pkg;

    localparam logic [31:0] DELTA       = 32'h9E3779B9;
    localparam int          KEY_SHIFT   = 11;
    localparam logic [6:0]  MAX_ROUNDS  = 7'd64;
    localparam logic [6:0]  RESET_ROUNDS = 7'd32;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ENCRYPT = 2'd1;
    localparam logic [1:0] CMD_DECRYPT = 2'd2;

    localparam logic [1:0] REG_KEY_HIGH    = 2'd0;
    localparam logic [1:0] REG_KEY_LOW     = 2'd1;
    localparam logic [1:0] REG_ROUND_COUNT = 2'd2;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [6:0]  round_count;
    } cfg_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] s;
    } round_state_t;

    function automatic logic [31:0] mix(input logic [31:0] w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

    function automatic logic [31:0] key_word(input logic [127:0] key, input logic [1:0] idx);
        logic [31:0] k;
        case (idx)
            2'd0:    k = key[127:96];
            2'd1:    k = key[95:64];
            2'd2:    k = key[63:32];
            default: k = key[31:0];
        endcase
        return k;
    endfunction

endpackage

@@ sv/xtea_if.sv @@
// Handshake channel interfaces: block requests, block results, register writes.
`timescale 1ns / 1ps

interface xtea_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] block_in;

    modport source (output valid, output command, output block_in, input ready);
    modport sink   (input valid, input command, input block_in, output ready);
endinterface

interface xtea_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_out;

    modport source (output valid, output block_out, input ready);
    modport sink   (input valid, input block_out, output ready);
endinterface

interface xtea_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/xtea_cbc_block_cipher.sv @@
// Top level: XTEA CBC block cipher with configuration registers.
//
// Channels: req (command, block_in) carries load-IV, encrypt and decrypt
// commands; rsp (block_out) returns one block per encrypt or decrypt; cfg
// writes key_high (index 0), key_low (index 1) and round_count (index 2).
// cfg is always ready; write it only while no block is in flight.
// A load-IV transfer returns nothing; command 3 is dropped.
// An encrypt or decrypt applies the shared round unit N times, N being
// round_count clamped to 64 (zero passes the block through the cipher
// unchanged), one XTEA cycle per clock; req ready stays low while a block is
// being worked, so the next request is taken only after the last block leaves
// the round unit.
// The finished block sits in an output register, so the next request is taken
// while it waits; a second result stalls the round unit until rsp is taken.
// Reset clears the chaining value and the key, sets round_count to 32 and
// drops rsp valid.
`timescale 1ns / 1ps

module xtea_cbc_block_cipher (
    input  logic     clk,
    input  logic     rst_n,
    xtea_req_if.sink   req,
    xtea_rsp_if.source rsp,
    xtea_cfg_if.sink   cfg
);

    xtea_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_high    <= 64'd0;
            cfg_reg.key_low     <= 64'd0;
            cfg_reg.round_count <= xtea_pkg::RESET_ROUNDS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                xtea_pkg::REG_KEY_HIGH:    cfg_reg.key_high    <= cfg.data;
                xtea_pkg::REG_KEY_LOW:     cfg_reg.key_low     <= cfg.data;
                xtea_pkg::REG_ROUND_COUNT: cfg_reg.round_count <= cfg.data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    xtea_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req_command (req.command),
        .req_block   (req.block_in),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .rsp_block   (rsp.block_out)
    );

endmodule

@@ sv/xtea_round.sv @@
// One full XTEA cycle (both half rounds), forward or inverse.
`timescale 1ns / 1ps

module xtea_round (
    input  logic                   decrypt,
    input  logic [127:0]           key,
    input  xtea_pkg::round_state_t cur,
    output xtea_pkg::round_state_t nxt
);

    logic [31:0] enc_a;
    logic [31:0] enc_s;
    logic [31:0] enc_b;
    logic [31:0] dec_b;
    logic [31:0] dec_s;
    logic [31:0] dec_a;

    always_comb
    begin
        enc_a = cur.a + (xtea_pkg::mix(cur.b) ^ (cur.s + xtea_pkg::key_word(key, cur.s[1:0])));
        enc_s = cur.s + xtea_pkg::DELTA;
        enc_b = cur.b + (xtea_pkg::mix(enc_a) ^ (enc_s + xtea_pkg::key_word(key,
                enc_s[xtea_pkg::KEY_SHIFT+1:xtea_pkg::KEY_SHIFT])));

        dec_b = cur.b - (xtea_pkg::mix(cur.a) ^ (cur.s + xtea_pkg::key_word(key,
                cur.s[xtea_pkg::KEY_SHIFT+1:xtea_pkg::KEY_SHIFT])));
        dec_s = cur.s - xtea_pkg::DELTA;
        dec_a = cur.a - (xtea_pkg::mix(dec_b) ^ (dec_s + xtea_pkg::key_word(key, dec_s[1:0])));

        if (decrypt)
        begin
            nxt.a = dec_a;
            nxt.b = dec_b;
            nxt.s = dec_s;
        end
        else
        begin
            nxt.a = enc_a;
            nxt.b = enc_b;
            nxt.s = enc_s;
        end
    end

endmodule

@@ sv/xtea_core.sv @@
// Sequencer: chaining value, round counter, shared round unit and result register.
`timescale 1ns / 1ps

module xtea_core (
    input  logic          clk,
    input  logic          rst_n,
    input  xtea_pkg::cfg_t cfg,
    input  logic          req_valid,
    output logic          req_ready,
    input  logic [1:0]    req_command,
    input  logic [63:0]   req_block,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output logic [63:0]   rsp_block
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                 state_reg, state_next;
    logic [6:0]             cnt_reg, cnt_next;
    logic                   dec_reg, dec_next;
    logic [63:0]            chain_reg, chain_next;
    logic [63:0]            ct_reg, ct_next;
    xtea_pkg::round_state_t rs_reg, rs_next;
    logic                   out_valid_reg, out_valid_next;
    logic [63:0]            out_block_reg, out_block_next;

    xtea_pkg::round_state_t rs_step;
    logic [6:0]             n_rounds;
    logic [31:0]            s_init;
    logic                   accept;
    logic                   finish;
    logic [63:0]            cipher_out;

    xtea_round u_round (
        .decrypt (dec_reg),
        .key     ({cfg.key_high, cfg.key_low}),
        .cur     (rs_reg),
        .nxt     (rs_step)
    );

    assign req_ready  = (state_reg == ST_IDLE);
    assign accept     = req_valid && req_ready;
    assign n_rounds   = (cfg.round_count > xtea_pkg::MAX_ROUNDS) ? xtea_pkg::MAX_ROUNDS
                                                                  : cfg.round_count;
    assign s_init     = xtea_pkg::DELTA * {25'd0, n_rounds};
    assign finish     = (state_reg == ST_RUN) && (cnt_reg == 7'd0)
                        && (!out_valid_reg || rsp_ready);
    assign cipher_out = {rs_reg.a, rs_reg.b};
    assign rsp_valid  = out_valid_reg;
    assign rsp_block  = out_block_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dec_next       = dec_reg;
        chain_next     = chain_reg;
        ct_next        = ct_reg;
        rs_next        = rs_reg;
        out_valid_next = out_valid_reg;
        out_block_next = out_block_reg;

        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_command)
                        xtea_pkg::CMD_LOAD:
                        begin
                            chain_next = req_block;
                        end
                        xtea_pkg::CMD_ENCRYPT:
                        begin
                            dec_next   = 1'b0;
                            cnt_next   = n_rounds;
                            rs_next.a  = req_block[63:32] ^ chain_reg[63:32];
                            rs_next.b  = req_block[31:0] ^ chain_reg[31:0];
                            rs_next.s  = 32'd0;
                            state_next = ST_RUN;
                        end
                        xtea_pkg::CMD_DECRYPT:
                        begin
                            dec_next   = 1'b1;
                            cnt_next   = n_rounds;
                            ct_next    = req_block;
                            rs_next.a  = req_block[63:32];
                            rs_next.b  = req_block[31:0];
                            rs_next.s  = s_init;
                            state_next = ST_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (cnt_reg != 7'd0)
                begin
                    rs_next  = rs_step;
                    cnt_next = cnt_reg - 7'd1;
                end
                else if (finish)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (dec_reg)
                    begin
                        out_block_next = cipher_out ^ chain_reg;
                        chain_next     = ct_reg;
                    end
                    else
                    begin
                        out_block_next = cipher_out;
                        chain_next     = cipher_out;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 7'd0;
            dec_reg       <= 1'b0;
            chain_reg     <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dec_reg       <= dec_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ct_reg        <= ct_next;
        rs_reg        <= rs_next;
        out_block_reg <= out_block_next;
    end

endmodule
